>>> src/hsld_pkg.sv
package hsld_pkg;

    localparam logic [63:0] HASH_SEED = 64'd5381;
    localparam int HASH_SHIFT = 5;
    localparam int LANE_FIELD_W = 6;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES = 64 / DIV_STEP_BITS;

    typedef enum logic [2:0] {
        CMD_OCC  = 3'b001,
        CMD_PUSH = 3'b010,
        CMD_PULL = 3'b100
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                   op;
        logic [LANE_FIELD_W-1:0]   lane;
        logic [63:0]               number;
    } cmd_t;

endpackage

>>> src/hsld_if.sv
interface hsld_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [63:0] op_number;
    logic [3:0]  lane;

    modport source (output valid, kind, key_byte, key_last, op_number, lane, input ready);
    modport sink   (input valid, kind, key_byte, key_last, op_number, lane, output ready);
endinterface

interface hsld_out_if;
    logic        valid;
    logic        ready;
    logic        pushed;
    logic [3:0]  chosen_lane;
    logic        push_dropped;
    logic        pulled_valid;
    logic [63:0] pulled_number;
    logic        pull_empty;
    logic [10:0] lane_occupancy;

    modport source (output valid, pushed, chosen_lane, push_dropped, pulled_valid,
                    pulled_number, pull_empty, lane_occupancy, input ready);
    modport sink   (input valid, pushed, chosen_lane, push_dropped, pulled_valid,
                    pulled_number, pull_empty, lane_occupancy, output ready);
endinterface

>>> src/hsld_ram.sv
module hsld_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/hsld_front.sv
module hsld_front #(
    parameter int MAX_LANES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        lane_count,
    hsld_in_if.sink           in_ch,
    output logic              q_push,
    output hsld_pkg::cmd_t    q_data,
    input  logic              q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    localparam int LW = hsld_pkg::LANE_FIELD_W;

    front_state_t state_reg, state_next;
    logic [63:0]  hash_reg, hash_next;
    logic [63:0]  div_reg, div_next;
    logic [4:0]   rem_reg, rem_next;
    logic [4:0]   n_reg, n_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic [63:0]  num_reg, num_next;

    logic [LW-1:0] wrap_tab [16];
    logic [63:0]   hash_new;
    logic          accept;
    logic [4:0]    n_eff;

    // lane field folded into range, table built at elaboration
    for (genvar g = 0; g < 16; g++)
    begin : g_wrap
        localparam int W = g % MAX_LANES;
        assign wrap_tab[g] = LW'(W);
    end

    assign hash_new = (hash_reg << hsld_pkg::HASH_SHIFT) + hash_reg + 64'(in_ch.key_byte);
    assign in_ch.ready = (state_reg == F_IDLE) && !q_full;
    assign accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (lane_count == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (32'(lane_count) > MAX_LANES)
        begin
            n_eff = 5'(MAX_LANES);
        end
        else
        begin
            n_eff = lane_count;
        end
    end

    always_comb
    begin
        logic [5:0]  t;
        logic [63:0] d;
        logic [4:0]  r;

        state_next = state_reg;
        hash_next  = hash_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        q_push     = 1'b0;
        q_data.op     = hsld_pkg::CMD_OCC;
        q_data.lane   = wrap_tab[in_ch.lane];
        q_data.number = num_reg;
        d = div_reg;
        r = rem_reg;
        t = '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.kind)
                    begin
                        q_push    = 1'b1;
                        q_data.op = hsld_pkg::CMD_PULL;
                    end
                    else if (!in_ch.key_last)
                    begin
                        q_push    = 1'b1;
                        hash_next = hash_new;
                    end
                    else
                    begin
                        hash_next  = hsld_pkg::HASH_SEED;
                        div_next   = hash_new;
                        rem_next   = '0;
                        cnt_next   = '0;
                        n_next     = n_eff;
                        num_next   = in_ch.op_number;
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                // restoring remainder, four dividend bits per cycle
                for (int k = 0; k < hsld_pkg::DIV_STEP_BITS; k++)
                begin
                    t = {r, d[63]};
                    d = d << 1;
                    if (t >= {1'b0, n_reg})
                    begin
                        t = t - {1'b0, n_reg};
                    end
                    r = t[4:0];
                end
                div_next = d;
                rem_next = r;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(hsld_pkg::DIV_CYCLES - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                q_data.op   = hsld_pkg::CMD_PUSH;
                q_data.lane = LW'(rem_reg);
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            hash_reg  <= hsld_pkg::HASH_SEED;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        n_reg   <= n_next;
        num_reg <= num_next;
    end

endmodule

>>> src/hsld_cmd_q.sv
module hsld_cmd_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsld_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output hsld_pkg::cmd_t  pop_data,
    output logic            empty
);

    hsld_pkg::cmd_t ent_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/hsld_back.sv
module hsld_back #(
    parameter int MAX_LANES  = 16,
    parameter int LANE_DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  hsld_pkg::cmd_t  q_data,
    output logic            q_pop,
    hsld_out_if.source      out_ch
);

    localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int PW = $clog2(LANE_DEPTH);
    localparam int FW = $clog2(LANE_DEPTH + 1);
    localparam int SD = MAX_LANES * LANE_DEPTH;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_WAIT = 2'b10
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic [PW-1:0] head_reg [MAX_LANES];
    logic [PW-1:0] tail_reg [MAX_LANES];
    logic [FW-1:0] fill_reg [MAX_LANES];

    logic          out_valid_reg, out_valid_next;
    logic          pushed_reg, pushed_next;
    logic [3:0]    chosen_reg, chosen_next;
    logic          dropped_reg, dropped_next;
    logic          pvalid_reg, pvalid_next;
    logic [63:0]   pnum_reg, pnum_next;
    logic          pempty_reg, pempty_next;
    logic [FW-1:0] occ_reg, occ_next;
    logic [FW+10:0] occ_ext;

    logic [LW-1:0] idx;
    logic [FW-1:0] fill_cur;
    logic [PW-1:0] head_cur, tail_cur;
    logic [AW-1:0] base;
    logic          out_free;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_rdata;
    logic          do_push, do_pull;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
        return (p == PW'(LANE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign idx      = q_data.lane[LW-1:0];
    assign fill_cur = fill_reg[idx];
    assign head_cur = head_reg[idx];
    assign tail_cur = tail_reg[idx];
    assign base     = AW'(idx) * AW'(LANE_DEPTH);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty && out_free;

    assign ram_waddr = base + AW'(tail_cur);
    assign ram_raddr = base + AW'(head_cur);
    assign ram_we    = do_push;
    assign ram_re    = do_pull;

    hsld_ram #(
        .WIDTH (64),
        .DEPTH (SD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_data.number),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        pushed_next    = pushed_reg;
        chosen_next    = chosen_reg;
        dropped_next   = dropped_reg;
        pvalid_next    = pvalid_reg;
        pnum_next      = pnum_reg;
        pempty_next    = pempty_reg;
        occ_next       = occ_reg;
        do_push        = 1'b0;
        do_pull        = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    out_valid_next = 1'b1;
                    pushed_next    = 1'b0;
                    chosen_next    = '0;
                    dropped_next   = 1'b0;
                    pvalid_next    = 1'b0;
                    pnum_next      = '0;
                    pempty_next    = 1'b0;
                    occ_next       = fill_cur;
                    unique case (q_data.op)
                        hsld_pkg::CMD_PUSH:
                        begin
                            chosen_next = q_data.lane[3:0];
                            if (fill_cur == FW'(LANE_DEPTH))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                do_push     = 1'b1;
                                pushed_next = 1'b1;
                                occ_next    = fill_cur + FW'(1);
                            end
                        end
                        hsld_pkg::CMD_PULL:
                        begin
                            if (fill_cur == '0)
                            begin
                                pempty_next = 1'b1;
                            end
                            else
                            begin
                                // store read is registered; result goes out from B_WAIT
                                do_pull        = 1'b1;
                                occ_next       = fill_cur - FW'(1);
                                out_valid_next = 1'b0;
                                state_next     = B_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_WAIT:
            begin
                out_valid_next = 1'b1;
                pvalid_next    = 1'b1;
                pnum_next      = ram_rdata;
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LANES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_push)
            begin
                tail_reg[idx] <= advance(tail_cur);
                fill_reg[idx] <= fill_cur + FW'(1);
            end
            if (do_pull)
            begin
                head_reg[idx] <= advance(head_cur);
                fill_reg[idx] <= fill_cur - FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pushed_reg  <= pushed_next;
        chosen_reg  <= chosen_next;
        dropped_reg <= dropped_next;
        pvalid_reg  <= pvalid_next;
        pnum_reg    <= pnum_next;
        pempty_reg  <= pempty_next;
        occ_reg     <= occ_next;
    end

    assign occ_ext = {11'b0, occ_reg};

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.pushed         = pushed_reg;
    assign out_ch.chosen_lane    = chosen_reg;
    assign out_ch.push_dropped   = dropped_reg;
    assign out_ch.pulled_valid   = pvalid_reg;
    assign out_ch.pulled_number  = pnum_reg;
    assign out_ch.pull_empty     = pempty_reg;
    assign out_ch.lane_occupancy = occ_ext[10:0];

endmodule

>>> src/hash_steered_lane_dispatch.sv
// Results pass through the command queue and the output register; a pull that finds
// data also waits on the registered store read in B_WAIT. Throughput: 1 item per
// cycle for bytes that are not last and for empty pulls while the receiver and the
// queue do not stall; a pull that finds data holds the back end in B_WAIT; a last
// byte holds input while the lane-count remainder unit takes the hash 4 bits per pass.
// Reset (rst_n, async, active low): hash back to 5381, all lanes empty, lane_count 1.
module hash_steered_lane_dispatch #(
    parameter int MAX_LANES  = 16,
    parameter int LANE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    hsld_in_if.sink     in_ch,
    hsld_out_if.source  out_ch
);

    logic [4:0]      lane_count_reg;
    logic            q_push, q_full, q_pop, q_empty;
    hsld_pkg::cmd_t  q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            lane_count_reg <= cfg_wdata;
        end
    end

    hsld_front #(
        .MAX_LANES (MAX_LANES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_count (lane_count_reg),
        .in_ch      (in_ch),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    hsld_cmd_q u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    hsld_back #(
        .MAX_LANES  (MAX_LANES),
        .LANE_DEPTH (LANE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

>>> src/hsld_checker.sv
module hsld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        pushed,
    input logic [3:0]  chosen_lane,
    input logic        push_dropped,
    input logic        pulled_valid,
    input logic [63:0] pulled_number,
    input logic        pull_empty,
    input logic [10:0] lane_occupancy
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulled_number)
            && $stable(lane_occupancy))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(pushed && push_dropped) && !(pulled_valid && pull_empty)
            && !((pushed || push_dropped) && (pulled_valid || pull_empty)))
        else $error("conflicting result flags");

    a_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pulled_valid |-> pulled_number == 64'd0)
        else $error("pulled_number set without a pull");

    a_lane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pushed && !push_dropped |-> chosen_lane == 4'd0)
        else $error("chosen_lane set without a key end");

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pushed || push_dropped) |-> lane_occupancy != 11'd0)
        else $error("key end left lane empty");

endmodule

bind hash_steered_lane_dispatch hsld_checker u_hsld_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .pushed         (out_ch.pushed),
    .chosen_lane    (out_ch.chosen_lane),
    .push_dropped   (out_ch.push_dropped),
    .pulled_valid   (out_ch.pulled_valid),
    .pulled_number  (out_ch.pulled_number),
    .pull_empty     (out_ch.pull_empty),
    .lane_occupancy (out_ch.lane_occupancy)
);

>>> test/tb_hash_steered_lane_dispatch.sv
module tb_hash_steered_lane_dispatch;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LANES = 16;
    localparam int DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        logic        kind;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [63:0] op_number;
        logic [3:0]  lane;
    } dispatch_item_t;

    typedef struct {
        logic        pushed;
        logic [3:0]  chosen_lane;
        logic        push_dropped;
        logic        pulled_valid;
        logic [63:0] pulled_number;
        logic        pull_empty;
        logic [10:0] lane_occupancy;
    } dispatch_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;

    hsld_in_if  in_ch ();
    hsld_out_if out_ch ();

    hash_steered_lane_dispatch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [63:0] key_hash;
    logic [63:0] lane_fifo [NUM_LANES][$];
    logic [4:0]  lanes_cfg;

    dispatch_item_t   pending_items [$];
    dispatch_result_t expected_results [$];

    int  mismatches;
    int  results_seen;
    int  pushes_seen;
    int  pulls_seen;
    int  drops_seen;
    int  empties_seen;
    longint cycles;
    bit  long_hold;
    bit  send_pause;
    int  burst_left;
    int  gap_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic dispatch_result_t dispatch_predict(dispatch_item_t it);
        dispatch_result_t r;
        int unsigned eff;
        int unsigned target;
        int unsigned pick;
        r = '{default: '0};
        target = it.lane;
        if (it.kind == 1'b0)
        begin
            key_hash = (key_hash << 5) + key_hash + {56'd0, it.key_byte};
            if (it.key_last)
            begin
                eff = (lanes_cfg == 0) ? 1 : ((lanes_cfg > NUM_LANES) ? NUM_LANES : lanes_cfg);
                pick = key_hash % eff;
                key_hash = 64'd5381;
                target = pick;
                r.chosen_lane = pick[3:0];
                if (lane_fifo[pick].size() >= DEPTH)
                    r.push_dropped = 1'b1;
                else
                begin
                    lane_fifo[pick].insert(lane_fifo[pick].size(), it.op_number);
                    r.pushed = 1'b1;
                end
            end
        end
        else
        begin
            if (lane_fifo[target].size() == 0)
                r.pull_empty = 1'b1;
            else
            begin
                r.pulled_number = lane_fifo[target].pop_front();
                r.pulled_valid = 1'b1;
            end
        end
        r.lane_occupancy = lane_fifo[target].size();
        return r;
    endfunction

    function automatic dispatch_item_t make_item(logic kind, logic [7:0] b, logic last,
                                                 logic [63:0] num, logic [3:0] lane);
        dispatch_item_t it;
        it.kind = kind;
        it.key_byte = b;
        it.key_last = last;
        it.op_number = num;
        it.lane = lane;
        return it;
    endfunction

    function automatic logic [63:0] rand_number();
        return {$urandom, $urandom};
    endfunction

    task automatic add_item(dispatch_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.insert(expected_results.size(),
                    dispatch_predict('{in_ch.kind, in_ch.key_byte, in_ch.key_last,
                                       in_ch.op_number, in_ch.lane}));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0 || send_pause || pending_items.size() == 0)
                begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    dispatch_item_t it;
                    it = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.kind <= it.kind;
                    in_ch.key_byte <= it.key_byte;
                    in_ch.key_last <= it.key_last;
                    in_ch.op_number <= it.op_number;
                    in_ch.lane <= it.lane;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
            end
        end
    end

    // receiver stall pattern and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                dispatch_result_t got;
                dispatch_result_t want;
                got = '{out_ch.pushed, out_ch.chosen_lane, out_ch.push_dropped,
                        out_ch.pulled_valid, out_ch.pulled_number, out_ch.pull_empty,
                        out_ch.lane_occupancy};
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result pushed=%0b lane=%0d occ=%0d",
                                 got.pushed, got.chosen_lane, got.lane_occupancy);
                end
                else
                begin
                    want = expected_results.pop_front();
                    pushes_seen += want.pushed;
                    pulls_seen += want.pulled_valid;
                    drops_seen += want.push_dropped;
                    empties_seen += want.pull_empty;
                    if (got.pushed !== want.pushed || got.chosen_lane !== want.chosen_lane ||
                        got.push_dropped !== want.push_dropped ||
                        got.pulled_valid !== want.pulled_valid ||
                        got.pulled_number !== want.pulled_number ||
                        got.pull_empty !== want.pull_empty ||
                        got.lane_occupancy !== want.lane_occupancy)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d exp push=%0b ln=%0d drop=%0b pv=%0b",
                                      " num=%h empty=%0b occ=%0d; got push=%0b ln=%0d",
                                      " drop=%0b pv=%0b num=%h empty=%0b occ=%0d"},
                                     results_seen, want.pushed, want.chosen_lane,
                                     want.push_dropped, want.pulled_valid,
                                     want.pulled_number, want.pull_empty,
                                     want.lane_occupancy, got.pushed, got.chosen_lane,
                                     got.push_dropped, got.pulled_valid,
                                     got.pulled_number, got.pull_empty,
                                     got.lane_occupancy);
                    end
                end
            end
            if (long_hold)
                out_ch.ready <= 1'b0;
            else if (cycles % 200 < 60)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(3, 0) != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_lanes(logic [4:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        lanes_cfg = v;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // a key of random length, content random, ending in a last byte
    task automatic queue_key();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
            add_item(make_item(1'b0, $urandom_range(255, 0),
                i == n - 1, rand_number(), $urandom_range(15, 0)));
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9, 0) < 6)
                queue_key();
            else
                add_item(make_item(1'b1, $urandom_range(255, 0),
                    $urandom_range(1, 0), rand_number(), $urandom_range(15, 0)));
        end
    endtask

    initial
    begin
        logic [4:0] settings [6];
        settings = '{5'd0, 5'd16, 5'd31, 5'd3, 5'd7, 5'd12};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.key_byte = '0;
        in_ch.key_last = 1'b0;
        in_ch.op_number = '0;
        in_ch.lane = '0;
        out_ch.ready = 1'b0;
        key_hash = 64'd5381;
        lanes_cfg = 5'd1;
        cycles = 0;
        mismatches = 0;
        long_hold = 1'b0;
        send_pause = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pulls, field extremes, pull mid-key, zero byte, wrap lanes
        add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        add_item(make_item(1'b1, 8'hff, 1'b1, '1, 4'd15));
        add_item(make_item(1'b0, 8'hff, 1'b0, 64'd0, 4'd15));
        add_item(make_item(1'b1, 8'h01, 1'b0, 64'd5, 4'd0));
        add_item(make_item(1'b0, 8'h00, 1'b1, '1, 4'd3));
        add_item(make_item(1'b0, 8'h01, 1'b1, 64'd0, 4'd0));
        add_item(make_item(1'b0, 8'h80, 1'b1, 64'h8000_0000_0000_0001, 4'd9));
        add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        drain();

        // fill lane 0 past full with lane count 1 while the receiver holds off
        long_hold = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
            add_item(make_item(1'b0, $urandom_range(255, 1), 1'b1,
                rand_number(), 4'd0));
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        drain();
        for (int i = 0; i < 24; i++)
            add_item(make_item(1'b1, 8'h00, 1'b0, 64'd0, 4'd0));
        drain();

        foreach (settings[s])
        begin
            write_lanes(settings[s]);
            queue_random(6);
            // sender pause until every result is back, then resume
            while (pending_items.size() != 0 || in_ch.valid)
                @(posedge clk);
            send_pause = 1'b1;
            while (expected_results.size() != 0)
                @(posedge clk);
            send_pause = 1'b0;
            queue_random(6);
            drain();
        end

        $display("Covered %0d results: %0d pushes, %0d pulls, %0d dropped, %0d empty pulls",
                 results_seen, pushes_seen, pulls_seen, drops_seen, empties_seen);
        $display("Lane counts swept from 0 to 31 including full-lane and empty-lane cases");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> files.f
src/hsld_pkg.sv
src/hsld_if.sv
src/hsld_ram.sv
src/hsld_front.sv
src/hsld_cmd_q.sv
src/hsld_back.sv
src/hash_steered_lane_dispatch.sv
src/hsld_checker.sv
test/tb_hash_steered_lane_dispatch.sv
